// ===== hdl/indexed_max_heap_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the indexed max-heap queue checker
// ----------------------------------------------------------------------------
`ifndef INDEXED_MAX_HEAP_QUEUE_MACROS_SVH
`define INDEXED_MAX_HEAP_QUEUE_MACROS_SVH

// implication checked on every edge outside reset
`define IMHQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define IMHQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/imhq_pkg.sv =====
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared types and constants for the indexed max-heap queue.
// ----------------------------------------------------------------------------
`default_nettype none
package imhq_pkg;
    localparam int CAPACITY_DEF      = 64;
    localparam int PRIORITY_BITS_DEF = 16;
    localparam int JOB_BITS          = 6;
    localparam int NUM_JOBS          = 64;
    localparam int PRIO_W            = 16;
    localparam int STAT_W            = 3;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_PEEK   = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_ABSENT = 3'd3;
    localparam logic [2:0] ST_DUP    = 3'd4;

    // datapath command codes
    typedef enum logic [3:0] {
        C_NONE, C_LOAD, C_CHECK, C_PLACE, C_TAKE, C_MOVE, C_RD_UP, C_UP,
        C_RD_DN, C_RD_DN2, C_DN, C_TOP, C_DONE
    } t_cmd;

    typedef struct packed {
        logic decided;   // check finished, result known
        logic err;       // error status, no change
        logic no_work;   // nothing to sift
        logic up_more;   // sift up swapped, continue
        logic up_stop;
        logic dn_more;
        logic dn_stop;
    } t_stat;
endpackage
`default_nettype wire

// ===== hdl/indexed_max_heap_queue.sv =====
// ----------------------------------------------------------------------------
// indexed_max_heap_queue
// Indexed binary max-heap of job ids with a job-to-slot map.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | word
//  in      | in        | i_valid / o_stall | op, job_id, priority_req
//  out     | out       | o_valid / i_stall | status, out ids, top, count
//
//  One word at a time. Each word is loaded and checked; peek and errors
//  then read the top. Push places the entry and sifts it up; pop and remove
//  take the entry, move the last one into the hole, sift up, then sift down.
//  One heap read-compare-swap per level; the top is read before the output.
//  Reset (synchronous, low) empties the queue; the map carries a valid bit
//  per job. The result is held while i_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none
module indexed_max_heap_queue #(
    parameter int CAPACITY      = imhq_pkg::CAPACITY_DEF,
    parameter int PRIORITY_BITS = imhq_pkg::PRIORITY_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [5:0]  i_job_id,
    input  wire logic [15:0] i_priority_req,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [5:0]       o_out_job_id,
    output logic [15:0]      o_out_priority,
    output logic             o_top_valid,
    output logic [5:0]       o_top_job_id,
    output logic [15:0]      o_top_priority,
    output logic [$clog2(CAPACITY+1)-1:0] o_count
);
    imhq_pkg::t_cmd  w_cmd;
    imhq_pkg::t_stat w_stat;

    imhq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_stat(w_stat), .i_op, .o_cmd(w_cmd)
    );

    imhq_dp #(.CAPACITY(CAPACITY), .PRIORITY_BITS(PRIORITY_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_op, .i_job_id, .i_priority_req,
        .o_stat(w_stat), .o_status, .o_out_job_id, .o_out_priority,
        .o_top_valid, .o_top_job_id, .o_top_priority, .o_count
    );
endmodule
`default_nettype wire

// ===== hdl/imhq_dp.sv =====
// ----------------------------------------------------------------------------
// imhq_dp
// Heap memories, position map and one compare-swap unit, one command a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module imhq_dp #(
    parameter int CAPACITY      = imhq_pkg::CAPACITY_DEF,
    parameter int PRIORITY_BITS = imhq_pkg::PRIORITY_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire imhq_pkg::t_cmd                 i_cmd,
    input  wire logic [1:0]                     i_op,
    input  wire logic [imhq_pkg::JOB_BITS-1:0]  i_job_id,
    input  wire logic [imhq_pkg::PRIO_W-1:0]    i_priority_req,
    output imhq_pkg::t_stat                     o_stat,
    output logic [imhq_pkg::STAT_W-1:0]         o_status,
    output logic [imhq_pkg::JOB_BITS-1:0]       o_out_job_id,
    output logic [imhq_pkg::PRIO_W-1:0]         o_out_priority,
    output logic                                o_top_valid,
    output logic [imhq_pkg::JOB_BITS-1:0]       o_top_job_id,
    output logic [imhq_pkg::PRIO_W-1:0]         o_top_priority,
    output logic [$clog2(CAPACITY+1)-1:0]       o_count
);
    localparam int SW = $clog2(CAPACITY);       // slot index
    localparam int FW = $clog2(CAPACITY+1);     // fill / map value
    localparam int JW = imhq_pkg::JOB_BITS;
    localparam int PW = PRIORITY_BITS;
    localparam int NJ = imhq_pkg::NUM_JOBS;

    typedef imhq_pkg::t_stat t_stat_l;

    // heap entry memory: {job, prio}
    logic [JW+PW-1:0] r_heap [CAPACITY];
    logic [FW-1:0]    r_map  [NJ];
    logic [NJ-1:0]    r_mval;             // map entry written since reset

    logic [FW-1:0] r_fill;
    logic [1:0]    r_op;
    logic [JW-1:0] r_job;
    logic [PW-1:0] r_prio;
    logic [FW-1:0] r_mrd;                 // registered map read of the job
    logic          r_mhit;                // map entry of the job was written
    logic [FW-1:0] r_jslot;               // map read of r_job
    logic [SW-1:0] r_s;                   // current slot
    logic [JW-1:0] r_sj;  logic [PW-1:0] r_sp;   // entry at r_s
    logic [JW-1:0] r_oj;  logic [PW-1:0] r_op2;  // other entry (parent/child)
    logic [SW-1:0] r_o;
    logic [JW-1:0] r_cj;  logic [PW-1:0] r_cp;   // last entry or right child staged
    logic          r_hasr;
    logic [JW+PW-1:0] r_rd;
    logic [imhq_pkg::STAT_W-1:0] r_status;
    logic [JW-1:0] r_xj;  logic [PW-1:0] r_xp;

    logic [FW-1:0] w_map_j;
    logic [SW:0]   w_par;
    logic [SW+1:0] w_left, w_right;
    logic          w_has_l, w_has_r;
    assign w_map_j = r_mhit ? r_mrd : FW'(CAPACITY);
    assign w_par   = (SW+1)'((r_s - 1'b1) >> 1);
    assign w_left  = {1'b0, r_s, 1'b1};
    assign w_right = w_left + 1'b1;
    assign w_has_l = w_left < (SW+2)'(r_fill);
    assign w_has_r = w_right < (SW+2)'(r_fill);

    t_stat_l st;

    always_comb begin
        st = '0;
        st.decided = 1'b1;
        st.err = (r_status != imhq_pkg::ST_OK);
        st.no_work = (r_op == imhq_pkg::OP_PEEK);
        st.up_more = (r_s != '0) && (r_op2 < r_sp);
        st.up_stop = !st.up_more;
        st.dn_more = w_has_l && (r_sp < r_op2);
        st.dn_stop = !st.dn_more;
    end
    assign o_stat = st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_mval <= '0;
        end else begin
            case (i_cmd)
                imhq_pkg::C_LOAD: begin
                    r_op <= i_op; r_job <= i_job_id;
                    r_prio <= PW'(i_priority_req);
                    r_mrd <= r_map[i_job_id];
                    r_mhit <= r_mval[i_job_id];
                    r_xj <= '0; r_xp <= '0;
                end
                imhq_pkg::C_CHECK: begin
                    r_jslot <= w_map_j;
                    r_status <= imhq_pkg::ST_OK;
                    // pop reads the top; remove reads the named job's slot
                    r_rd <= r_heap[SW'((r_op == imhq_pkg::OP_REMOVE && w_map_j < r_fill)
                                       ? w_map_j : '0)];
                    case (r_op)
                        imhq_pkg::OP_PUSH:
                            if (w_map_j < r_fill) r_status <= imhq_pkg::ST_DUP;
                            else if (r_fill == FW'(CAPACITY))
                                r_status <= imhq_pkg::ST_FULL;
                        imhq_pkg::OP_POP, imhq_pkg::OP_PEEK:
                            if (r_fill == '0) r_status <= imhq_pkg::ST_EMPTY;
                        default:
                            if (w_map_j >= r_fill) r_status <= imhq_pkg::ST_ABSENT;
                    endcase
                end
                imhq_pkg::C_PLACE: begin   // push: write at fill
                    r_heap[SW'(r_fill)] <= {r_job, r_prio};
                    r_map[r_job] <= r_fill; r_mval[r_job] <= 1'b1;
                    r_s <= SW'(r_fill); r_sj <= r_job; r_sp <= r_prio;
                    r_fill <= r_fill + 1'b1;
                end
                imhq_pkg::C_TAKE: begin    // pop/remove: record, read last
                    r_s <= (r_op == imhq_pkg::OP_POP) ? '0 : SW'(r_jslot);
                    r_xj <= r_rd[JW+PW-1:PW]; r_xp <= r_rd[PW-1:0];
                    r_map[r_rd[JW+PW-1:PW]] <= FW'(CAPACITY);
                    r_mval[r_rd[JW+PW-1:PW]] <= 1'b1;
                    r_cj <= r_heap[SW'(r_fill - 1'b1)][JW+PW-1:PW];
                    r_cp <= r_heap[SW'(r_fill - 1'b1)][PW-1:0];
                    r_fill <= r_fill - 1'b1;
                end
                imhq_pkg::C_MOVE: begin    // last into hole
                    if (FW'(r_s) < r_fill) begin
                        r_heap[r_s] <= {r_cj, r_cp};
                        r_map[r_cj] <= FW'(r_s);
                    end
                    r_sj <= r_cj; r_sp <= r_cp;
                end
                imhq_pkg::C_RD_UP: begin
                    r_o <= SW'(w_par);
                    {r_oj, r_op2} <= r_heap[SW'(w_par)];
                end
                imhq_pkg::C_UP, imhq_pkg::C_DN: begin   // swap r_s with r_o
                    r_heap[r_o] <= {r_sj, r_sp};
                    r_heap[r_s] <= {r_oj, r_op2};
                    r_map[r_sj] <= FW'(r_o);
                    r_map[r_oj] <= FW'(r_s);
                    r_s <= r_o;
                end
                imhq_pkg::C_RD_DN: begin
                    r_hasr <= w_has_r;
                    r_o <= SW'(w_left);
                    if (w_has_l) {r_oj, r_op2} <= r_heap[SW'(w_left)];
                    else begin r_oj <= '0; r_op2 <= '0; end
                    if (w_has_r) {r_cj, r_cp} <= r_heap[SW'(w_right)];
                end
                imhq_pkg::C_RD_DN2: begin
                    if (r_hasr && r_cp > r_op2) begin
                        r_o <= SW'(w_right); r_oj <= r_cj; r_op2 <= r_cp;
                    end
                end
                imhq_pkg::C_TOP: r_rd <= r_heap[0];
                default: ;
            endcase
        end
    end

    assign o_status       = r_status;
    assign o_out_job_id   = r_xj;
    assign o_out_priority = imhq_pkg::PRIO_W'(r_xp);
    assign o_top_valid    = (r_fill != '0);
    assign o_top_job_id   = o_top_valid ? r_rd[JW+PW-1:PW] : '0;
    assign o_top_priority = o_top_valid ? imhq_pkg::PRIO_W'(r_rd[PW-1:0]) : '0;
    assign o_count        = r_fill;
endmodule
`default_nettype wire

// ===== hdl/imhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// imhq_ctrl
// Sequencer: handshake, check, place/take, sift up then down, top read.
// ----------------------------------------------------------------------------
`default_nettype none
module imhq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  wire logic            i_stall,
    input  wire imhq_pkg::t_stat i_stat,
    input  wire logic [1:0]      i_op,
    output imhq_pkg::t_cmd       o_cmd
);
    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001, S_CHK  = 10'b0000000010,
        S_DEC  = 10'b0000000100, S_MOVE = 10'b0000001000,
        S_RUP  = 10'b0000010000, S_UP   = 10'b0000100000,
        S_RDN  = 10'b0001000000, S_RDN2 = 10'b0010000000,
        S_DN   = 10'b0100000000, S_OUT  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_top;       // top read pending flag; n_top never sets it
    logic   r_push;
    logic   n_top;

    always_comb begin
        n_state = r_state;
        n_top   = 1'b0;
        o_cmd   = imhq_pkg::C_NONE;
        case (r_state)
            S_IDLE: if (i_valid) begin o_cmd = imhq_pkg::C_LOAD; n_state = S_CHK; end
            S_CHK: begin o_cmd = imhq_pkg::C_CHECK; n_state = S_DEC; end
            S_DEC: begin
                if (i_stat.err || i_stat.no_work) begin
                    o_cmd = imhq_pkg::C_TOP; n_state = S_OUT;
                end else if (r_push) begin
                    o_cmd = imhq_pkg::C_PLACE; n_state = S_RUP;
                end else begin
                    o_cmd = imhq_pkg::C_TAKE; n_state = S_MOVE;
                end
            end
            S_MOVE: begin o_cmd = imhq_pkg::C_MOVE; n_state = S_RUP; end
            S_RUP: begin o_cmd = imhq_pkg::C_RD_UP; n_state = S_UP; end
            S_UP: begin
                if (i_stat.up_more) begin o_cmd = imhq_pkg::C_UP; n_state = S_RUP; end
                else if (r_push) begin o_cmd = imhq_pkg::C_TOP; n_state = S_OUT; end
                else n_state = S_RDN;
            end
            S_RDN: begin o_cmd = imhq_pkg::C_RD_DN; n_state = S_RDN2; end
            S_RDN2: begin o_cmd = imhq_pkg::C_RD_DN2; n_state = S_DN; end
            S_DN: begin
                if (i_stat.dn_more) begin o_cmd = imhq_pkg::C_DN; n_state = S_RDN; end
                else begin o_cmd = imhq_pkg::C_TOP; n_state = S_OUT; end
            end
            S_OUT: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_push  <= 1'b0;
            r_top   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            if (r_state == S_IDLE && i_valid) r_push <= (i_op == imhq_pkg::OP_PUSH);
        end
    end

    assign o_stall = (r_state != S_IDLE) || r_top;
    assign o_valid = (r_state == S_OUT);
endmodule
`default_nettype wire

// ===== hdl/imhq_checker.sv =====
// ----------------------------------------------------------------------------
// imhq_assert
// Port-level checks on the queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_max_heap_queue_macros.svh"
module imhq_assert (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [2:0] o_status,
    input wire logic       o_top_valid,
    input wire logic [5:0] o_top_job_id
);
    `IMHQ_ASSERT_IMP(a_busy, i_clk, i_rst_n, o_valid, o_stall)
    `IMHQ_ASSERT_IMP(a_top, i_clk, i_rst_n, o_valid && !o_top_valid, o_top_job_id == 6'd0)
    `IMHQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status))
endmodule
bind indexed_max_heap_queue imhq_assert u_chk (.*);
`default_nettype wire

// ===== verif/imhq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_checker
// Watches both channels of the heap queue, keeps its own heap with a job map,
// predicts one result word per accepted input word and compares in order.
// ----------------------------------------------------------------------------
module imhq_checker
    import imhq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_op,
    input  logic [5:0]  i_job_id,
    input  logic [15:0] i_priority_req,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [5:0]  i_out_job_id,
    input  logic [15:0] i_out_priority,
    input  logic        i_top_valid,
    input  logic [5:0]  i_top_job_id,
    input  logic [15:0] i_top_priority,
    input  logic [6:0]  i_count,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_queued
);
    localparam int CAP = CAPACITY_DEF;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  out_job;
        logic [15:0] out_prio;
        logic        top_valid;
        logic [5:0]  top_job;
        logic [15:0] top_prio;
        logic [6:0]  count;
    } t_result;

    logic [5:0]  hjob [CAP];
    logic [15:0] hprio [CAP];
    int          slot_of [NUM_JOBS];
    int          fill;
    t_result     expected_q [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_q.size();
    assign o_queued     = fill;

    function automatic void swap_slots(int a, int b);
        logic [5:0]  j;
        logic [15:0] p;
        j = hjob[a]; p = hprio[a];
        hjob[a] = hjob[b]; hprio[a] = hprio[b];
        hjob[b] = j; hprio[b] = p;
        slot_of[hjob[a]] = a;
        slot_of[hjob[b]] = b;
    endfunction

    function automatic void climb(int s);
        int par;
        while (s > 0 && s < fill) begin
            par = (s - 1) / 2;
            if (hprio[par] < hprio[s]) begin
                swap_slots(par, s);
                s = par;
            end else break;
        end
    endfunction

    function automatic void sink(int s);
        int l, c;
        while (s < fill) begin
            l = 2 * s + 1;
            if (l >= fill) break;
            c = l;
            if (l + 1 < fill && hprio[l + 1] > hprio[l]) c = l + 1;
            if (hprio[s] < hprio[c]) begin
                swap_slots(s, c);
                s = c;
            end else break;
        end
    endfunction

    // last job fills the hole, then climbs and sinks
    function automatic void take_slot(int s);
        int last;
        last = fill - 1;
        slot_of[hjob[s]] = CAP;
        if (s != last) begin
            hjob[s] = hjob[last];
            hprio[s] = hprio[last];
            slot_of[hjob[s]] = s;
        end
        fill = last;
        if (s < fill) begin
            climb(s);
            s = slot_of[hjob[s]];
            if (s < fill) sink(s);
        end
    endfunction

    function automatic t_result apply_word(logic [1:0] op, logic [5:0] job,
                                           logic [15:0] prio);
        t_result r;
        int s;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (slot_of[job] < fill) r.status = ST_DUP;
                else if (fill >= CAP) r.status = ST_FULL;
                else begin
                    s = fill;
                    hjob[s] = job; hprio[s] = prio;
                    slot_of[job] = s;
                    fill = s + 1;
                    climb(s);
                end
            end
            OP_POP: begin
                if (fill == 0) r.status = ST_EMPTY;
                else begin
                    r.out_job = hjob[0]; r.out_prio = hprio[0];
                    take_slot(0);
                end
            end
            OP_REMOVE: begin
                s = slot_of[job];
                if (s >= fill) r.status = ST_ABSENT;
                else begin
                    r.out_job = hjob[s]; r.out_prio = hprio[s];
                    take_slot(s);
                end
            end
            default: if (fill == 0) r.status = ST_EMPTY;
        endcase
        if (fill > 0) begin
            r.top_valid = 1'b1;
            r.top_job = hjob[0];
            r.top_prio = hprio[0];
        end
        r.count = 7'(fill);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_JOBS; i++) slot_of[i] = CAP;
            fill = 0;
            fails = 0;
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_status, i_out_job_id, i_out_priority, i_top_valid,
                        i_top_job_id, i_top_priority, i_count};
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result word %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("mismatch: expected st=%0d oj=%0d op=%0d tv=%0d tj=%0d tp=%0d n=%0d",
                                     want.status, want.out_job, want.out_prio,
                                     want.top_valid, want.top_job, want.top_prio,
                                     want.count);
                            $display("          got      st=%0d oj=%0d op=%0d tv=%0d tj=%0d tp=%0d n=%0d",
                                     got.status, got.out_job, got.out_prio,
                                     got.top_valid, got.top_job, got.top_prio,
                                     got.count);
                        end
                    end
                end
            end
            if (i_valid && !i_in_stall)
                expected_q = {expected_q, apply_word(i_op, i_job_id, i_priority_req)};
        end
    end
endmodule

// ===== verif/tb_indexed_max_heap_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_max_heap_queue
// Drives push, pop, remove and peek words with random gaps and output stalls;
// the checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_indexed_max_heap_queue;
    import imhq_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = OP_PEEK;
    logic [5:0]  job = '0;
    logic [15:0] prio = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [5:0]  out_job;
    logic [15:0] out_prio;
    logic        top_valid;
    logic [5:0]  top_job;
    logic [15:0] top_prio;
    logic [6:0]  count;
    int          fail_count, pending, queued;
    int          cycles = 0;
    bit          calm = 1'b0;   // long stretch with no idling on either side

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    indexed_max_heap_queue i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_op(op), .i_job_id(job), .i_priority_req(prio),
        .o_valid(out_valid), .i_stall(out_stall), .o_status(status),
        .o_out_job_id(out_job), .o_out_priority(out_prio),
        .o_top_valid(top_valid), .o_top_job_id(top_job),
        .o_top_priority(top_prio), .o_count(count)
    );

    imhq_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_op(op), .i_job_id(job), .i_priority_req(prio),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_status(status),
        .i_out_job_id(out_job), .i_out_priority(out_prio),
        .i_top_valid(top_valid), .i_top_job_id(top_job),
        .i_top_priority(top_prio), .i_count(count),
        .o_fail_count(fail_count), .o_pending(pending), .o_queued(queued)
    );

    // receiver stalls about 18 percent of the time, except in the calm stretch
    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < 18);
    end

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one word: optional idle gap, then hold valid until accepted
    task automatic send_word(logic [1:0] o, logic [5:0] j, logic [15:0] p);
        while (!calm && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        job <= j;
        prio <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // mostly well-formed traffic; op mix leans on the current fill level
    task automatic random_word();
        int r;
        logic [15:0] p;
        r = $urandom_range(99);
        // narrow priorities now and then so that ties happen
        p = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
        if (queued < 8 && r < 60) send_word(OP_PUSH, 6'($urandom), p);
        else if (queued > 56 && r < 55) send_word(OP_POP, 6'($urandom), p);
        else if (r < 40) send_word(OP_PUSH, 6'($urandom), p);
        else if (r < 65) send_word(OP_POP, 6'($urandom), p);
        else if (r < 92) send_word(OP_REMOVE, 6'($urandom), p);
        else send_word(OP_PEEK, 6'($urandom), p);
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-queue errors, extremes, duplicate, drain to empty
        send_word(OP_POP, 6'd0, 16'd0);
        send_word(OP_PEEK, 6'd63, 16'hFFFF);
        send_word(OP_REMOVE, 6'd5, 16'd0);
        send_word(OP_PUSH, 6'd0, 16'd0);
        send_word(OP_PUSH, 6'd63, 16'hFFFF);
        send_word(OP_PUSH, 6'd63, 16'd1);
        send_word(OP_PUSH, 6'd21, 16'h5555);
        send_word(OP_PUSH, 6'd42, 16'hAAAA);
        send_word(OP_PUSH, 6'd7, 16'hAAAA);
        send_word(OP_PEEK, 6'd0, 16'd0);
        send_word(OP_REMOVE, 6'd21, 16'd0);
        send_word(OP_REMOVE, 6'd21, 16'd0);
        send_word(OP_POP, 6'd0, 16'd0);
        send_word(OP_REMOVE, 6'd0, 16'd0);
        send_word(OP_POP, 6'd0, 16'd0);
        send_word(OP_POP, 6'd0, 16'd0);
        send_word(OP_POP, 6'd0, 16'd0);
        // full queue, then push of a new job while a job is gone
        for (int i = 0; i < 64; i++) send_word(OP_PUSH, 6'(i), 16'($urandom));
        send_word(OP_PUSH, 6'd10, 16'd3);
        send_word(OP_REMOVE, 6'd10, 16'd0);
        send_word(OP_PUSH, 6'd10, 16'hFFFF);
        send_word(OP_PUSH, 6'd11, 16'hFFFF);
        // remove words with random job ids, so some find their job absent
        for (int i = 0; i < 70; i++) send_word(OP_REMOVE, 6'($urandom), 16'd0);

        for (int n = 0; n < 1000; n++) begin
            calm = (n >= 400 && n < 600);
            random_word();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/imhq_pkg.sv
hdl/imhq_dp.sv
hdl/imhq_ctrl.sv
hdl/indexed_max_heap_queue.sv
hdl/imhq_checker.sv
verif/imhq_checker.sv
verif/tb_indexed_max_heap_queue.sv
